[src/bdpc_pkg.sv]
package bdpc_pkg;

	// Width of the threshold registers and of the configuration data.
	localparam int unsigned TICKS_W = 16;

	// Reset values of the threshold registers.
	localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [TICKS_W-1:0] LONG_RESET     = 16'd1000;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_DEBOUNCE = 1'b0,
		CFG_LONG     = 1'b1
	} cfg_index_t;

	// Press classes as reported and latched.
	typedef enum logic [1:0] {
		CODE_NONE  = 2'd0,
		CODE_SHORT = 2'd1,
		CODE_LONG  = 2'd2
	} press_code_t;

	// Thresholds handed from the register file to the classifier.
	typedef struct packed {
		logic [TICKS_W-1:0] debounce_ticks;
		logic [TICKS_W-1:0] long_ticks;
	} bdpc_cfg_t;

	// One result item.
	typedef struct packed {
		logic [1:0] press_code;
		logic       press_pending;
	} bdpc_result_t;

endpackage

[src/bdpc_cfg_regs.sv]
module bdpc_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [0:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	output bdpc_pkg::bdpc_cfg_t       cfg
);
	import bdpc_pkg::*;

	logic [TICKS_W-1:0] debounce_q;
	logic [TICKS_W-1:0] long_q;

	// Threshold registers, written on each configuration transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			long_q     <= LONG_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_DEBOUNCE: debounce_q <= cfg_data;
				CFG_LONG:     long_q     <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign cfg.debounce_ticks = debounce_q;
	assign cfg.long_ticks     = long_q;

endmodule

[src/bdpc_classifier.sv]
module bdpc_classifier #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,
	input  logic                   button_level,
	input  logic                   read_request,
	input  bdpc_pkg::bdpc_cfg_t    cfg,
	output bdpc_pkg::bdpc_result_t result
);
	import bdpc_pkg::*;

	localparam int unsigned CMP_W = (COUNT_WIDTH > TICKS_W) ? COUNT_WIDTH : TICKS_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		PH_UP         = 2'd0,
		PH_DEBOUNCING = 2'd1,
		PH_DOWN       = 2'd2
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_inc, elapsed_d;
	press_code_t            code_q, code_latch, code_d;
	logic [CMP_W-1:0]       elapsed_cmp;
	logic                   debounce_met;
	logic                   long_met;

	// Saturating count while the button is not up.
	always_comb begin
		elapsed_inc = elapsed_q;
		if (phase_q != PH_UP && elapsed_q != COUNT_MAX) begin
			elapsed_inc = elapsed_q + 1'b1;
		end
	end

	// Compare at a common width so a threshold above the counter range never matches.
	assign elapsed_cmp  = CMP_W'(elapsed_inc);
	assign debounce_met = elapsed_cmp >= CMP_W'(cfg.debounce_ticks);
	assign long_met     = elapsed_cmp >= CMP_W'(cfg.long_ticks);

	// Phase transitions and press classification on release.
	always_comb begin
		phase_d    = phase_q;
		elapsed_d  = elapsed_inc;
		code_latch = code_q;
		unique case (phase_q)
			PH_DEBOUNCING: begin
				if (!button_level) begin
					phase_d = PH_UP;
				end else if (debounce_met) begin
					phase_d = PH_DOWN;
				end
			end
			PH_DOWN: begin
				if (!button_level) begin
					phase_d    = PH_UP;
					code_latch = long_met ? CODE_LONG : CODE_SHORT;
				end
			end
			default: begin
				phase_d = PH_UP;
				if (button_level) begin
					elapsed_d = '0;
					phase_d   = PH_DEBOUNCING;
				end
			end
		endcase
	end

	// A read returns the code held before this tick and clears it unless a
	// different code was latched in the same tick.
	always_comb begin
		code_d            = code_latch;
		result.press_code = CODE_NONE;
		if (read_request) begin
			result.press_code = code_q;
			if (code_latch == code_q) begin
				code_d = CODE_NONE;
			end
		end
		result.press_pending = (code_d != CODE_NONE);
	end

	// Machine state, advanced once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_UP;
			elapsed_q <= '0;
			code_q    <= CODE_NONE;
		end else if (tick) begin
			phase_q   <= phase_d;
			elapsed_q <= elapsed_d;
			code_q    <= code_d;
		end
	end

endmodule

[src/bdpc_out_buf.sv]
module bdpc_out_buf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bdpc_pkg::bdpc_result_t push_data,
	output logic                   space,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bdpc_pkg::bdpc_result_t out_data
);
	import bdpc_pkg::*;

	logic         main_valid_q;
	logic         skid_valid_q;
	bdpc_result_t main_q;
	bdpc_result_t skid_q;
	logic         pop;

	assign pop       = main_valid_q & out_ready;
	assign space     = ~skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Occupancy of the output register and the skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// Payload moves forward; no reset needed.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

[src/button_debounce_press_classifier.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | button_level, read_request (one tick)
// out      | out_valid / out_ready| press_code[1:0], press_pending
// cfg      | cfg_valid / cfg_ready| cfg_index (0 debounce, 1 long), cfg_data
//
// One tick is taken per cycle while in_ready is high; the buffer registers its
// result. The state update is a single pass of compare and select logic.
// Reset clears the phase, the elapsed counter and the latched code, and loads
// the thresholds with 50 and 1000. A two-entry output buffer lets ticks keep
// flowing while a result waits; in_ready drops only when both entries are full.
// cfg_ready is always high.
module button_debounce_press_classifier #(
	parameter int unsigned COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        button_level,
	input  logic        read_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  press_code,
	output logic        press_pending,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bdpc_pkg::*;

	bdpc_cfg_t    cfg;
	bdpc_result_t result;
	bdpc_result_t out_data;
	logic         tick;

	assign cfg_ready = 1'b1;
	assign tick      = in_valid & in_ready;

	// Threshold registers.
	bdpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Debounce machine and press classifier.
	bdpc_classifier #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_cls (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.button_level (button_level),
		.read_request (read_request),
		.cfg          (cfg),
		.result       (result)
	);

	// Result register with skid entry.
	bdpc_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (tick),
		.push_data (result),
		.space     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign press_code    = out_data.press_code;
	assign press_pending = out_data.press_pending;

	// A full buffer always has its head result on offer.
	a_full_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result on offer");

	// A transfer into an empty buffer shows up at the output next cycle.
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |=> out_valid)
		else $error("accepted tick produced no result");

	// The unused class code is never reported.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (press_code != 2'd3))
		else $error("invalid press code on output");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

	import bdpc_pkg::*;

	// Phases of the button as the checker tracks them.
	typedef enum logic [1:0] {
		ST_RELEASED = 2'd0,
		ST_SETTLING = 2'd1,
		ST_PRESSED  = 2'd2
	} btn_state_t;

	localparam logic [15:0] HOLD_MAX = 16'hFFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        button_level = 1'b0;
	logic        read_request = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  press_code;
	logic        press_pending;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = CFG_DEBOUNCE;
	logic [15:0] cfg_data = 16'd0;

	// Checker copy of the block state and thresholds.
	btn_state_t  btn_state;
	logic [15:0] hold_count;
	press_code_t stored_code;
	logic [15:0] debounce_cfg;
	logic [15:0] long_cfg;

	// Press reports expected from the block, oldest first.
	bdpc_result_t press_reports_q[$];
	int           error_count = 0;

	// Idle controls for the sender (gaps) and for the receiver (stalls and hold-offs).
	bit gap_enable = 1'b0;
	bit stall_enable = 1'b0;
	int hold_request = 0;
	int stall_left = 0;

	button_debounce_press_classifier #(
		.COUNT_WIDTH(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_level(button_level),
		.read_request(read_request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.press_code(press_code),
		.press_pending(press_pending),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit well beyond the slowest legal run.
	initial begin
		#20000000;
		$display("tb: errors");
		$finish;
	end

	// Advance the checker state by one tick and return the report it causes.
	function automatic bdpc_result_t classify_tick(input logic lvl, input logic rd);
		bdpc_result_t rep;
		press_code_t  prior;
		prior = stored_code;
		if (btn_state != ST_RELEASED && hold_count != HOLD_MAX)
			hold_count = hold_count + 16'd1;
		case (btn_state)
			ST_SETTLING: begin
				if (!lvl)
					btn_state = ST_RELEASED;
				else if (hold_count >= debounce_cfg)
					btn_state = ST_PRESSED;
			end
			ST_PRESSED: begin
				if (!lvl) begin
					btn_state = ST_RELEASED;
					stored_code = (hold_count >= long_cfg) ? CODE_LONG : CODE_SHORT;
				end
			end
			default: begin
				btn_state = ST_RELEASED;
				if (lvl) begin
					hold_count = 16'd0;
					btn_state = ST_SETTLING;
				end
			end
		endcase
		rep.press_code = CODE_NONE;
		if (rd) begin
			rep.press_code = prior;
			// A different code latched by a release in this same tick survives the read.
			if (stored_code == prior)
				stored_code = CODE_NONE;
		end
		rep.press_pending = (stored_code != CODE_NONE);
		return rep;
	endfunction

	// Offer one tick, optionally after a random gap, and record its report.
	task automatic send_tick(input logic lvl, input logic rd);
		int gap;
		if (gap_enable && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 19);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		button_level <= lvl;
		read_request <= rd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		press_reports_q.push_back(classify_tick(lvl, rd));
	endtask

	// Stop offering ticks and wait for every outstanding report.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (press_reports_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// One transfer on the configuration channel.
	task automatic write_threshold(input cfg_index_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_DEBOUNCE)
			debounce_cfg = val;
		else
			long_cfg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_thresholds(input logic [15:0] deb, input logic [15:0] lng);
		settle();
		write_threshold(CFG_DEBOUNCE, deb);
		write_threshold(CFG_LONG, lng);
	endtask

	// Hold the button for a number of ticks, then release it for a number of ticks.
	task automatic press_for(input int hold, input int rel, input int read_odds);
		repeat (hold) send_tick(1'b1, read_odds != 0 && $urandom_range(0, read_odds - 1) == 0);
		repeat (rel) send_tick(1'b0, read_odds != 0 && $urandom_range(0, read_odds - 1) == 0);
	endtask

	// Reset thresholds give a short press for a hold past 50 ticks.
	task automatic test_default_thresholds();
		press_for(55, 1, 0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b1);
	endtask

	// Zero thresholds accept on the first settling tick and make every press long.
	task automatic test_zero_thresholds();
		set_thresholds(16'd0, 16'd0);
		press_for(1, 1, 0);
		press_for(2, 1, 0);
		send_tick(1'b0, 1'b1);
	endtask

	// A newer press overwrites an unread one, and a read in the release tick
	// returns the older code while the new one stays pending.
	task automatic test_read_and_overwrite();
		set_thresholds(16'd1, 16'd3);
		press_for(2, 1, 0);
		press_for(4, 1, 0);
		press_for(2, 0, 0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
	endtask

	// Thresholds far above the hold length are never met.
	task automatic test_large_thresholds();
		// The press is never accepted, so its release latches nothing.
		set_thresholds(16'hFFFF, 16'hFFFF);
		press_for(300, 1, 0);
		send_tick(1'b0, 1'b1);
		// The press is accepted but stays short of the long threshold.
		set_thresholds(16'd100, 16'hFFFF);
		press_for(300, 1, 0);
		send_tick(1'b0, 1'b1);
	endtask

	// The receiver holds off long enough to fill the block and stall its input.
	task automatic test_backpressure();
		set_thresholds(16'd2, 16'd6);
		hold_request = 200;
		repeat (40) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		settle();
	endtask

	// Mostly well-formed presses with random length and reads, plus bounces and noise.
	task automatic test_random_presses(input int budget, input logic [15:0] deb,
			input logic [15:0] lng);
		int sent;
		int kind;
		int hmin;
		int hmax;
		int hold;
		int rel;
		set_thresholds(deb, lng);
		sent = 0;
		while (sent < budget) begin
			kind = $urandom_range(0, 9);
			hmin = (deb < 1) ? 2 : int'(deb) + 1;
			hmax = ((lng > 40) ? 40 : int'(lng)) + 3;
			if (kind <= 6) begin
				hold = $urandom_range(hmin, (hmax > hmin) ? hmax : hmin);
				rel = $urandom_range(1, 4);
				press_for(hold, rel, 4);
				sent += hold + rel;
			end else if (kind == 7) begin
				hold = $urandom_range(1, (hmin > 2) ? hmin - 1 : 1);
				press_for(hold, 1, 4);
				sent += hold + 1;
			end else begin
				hold = $urandom_range(1, 8);
				repeat (hold)
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent += hold;
			end
		end
	endtask

	// Receiver: long hold-offs on request, random stall bursts otherwise.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				out_ready <= 1'b0;
				hold_request = hold_request - 1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left = stall_left - 1;
			end else if (stall_enable && $urandom_range(0, 15) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare every report transfer against the oldest expectation.
	initial begin
		bdpc_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (press_reports_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected report, actual code %0d pending %0b",
						$time, press_code, press_pending);
				end else begin
					want = press_reports_q.pop_front();
					if (press_code !== want.press_code) begin
						error_count++;
						$display("%0t: press_code expected %0d actual %0d",
							$time, want.press_code, press_code);
					end
					if (press_pending !== want.press_pending) begin
						error_count++;
						$display("%0t: press_pending expected %0b actual %0b",
							$time, want.press_pending, press_pending);
					end
				end
			end
		end
	end

	// Main sequence.
	initial begin
		int wait_cycles;
		btn_state = ST_RELEASED;
		hold_count = 16'd0;
		stored_code = CODE_NONE;
		debounce_cfg = DEBOUNCE_RESET;
		long_cfg = LONG_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_thresholds();
		test_zero_thresholds();
		test_read_and_overwrite();
		test_large_thresholds();

		gap_enable = 1'b1;
		stall_enable = 1'b1;
		test_backpressure();
		test_random_presses(400, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 26)));
		test_random_presses(400, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 26)));
		test_random_presses(200, 16'd0, 16'd0);
		test_random_presses(200, 16'd0, 16'hFFFF);

		// Final stretch runs with both sides idle-free.
		gap_enable = 1'b0;
		stall_enable = 1'b0;
		test_random_presses(300, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 26)));

		@(negedge clk);
		in_valid <= 1'b0;
		wait_cycles = 0;
		while (press_reports_q.size() != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (press_reports_q.size() != 0) begin
			error_count++;
			$display("%0t: %0d expected reports never arrived", $time,
				press_reports_q.size());
		end
		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
